[src/perspective_warp_bilinear_assert.svh]
// ---------------------------------------------------------------------------
// perspective_warp_bilinear assertion macros
// Concurrent assertion shorthands; compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef PERSPECTIVE_WARP_BILINEAR_ASSERT_SVH
`define PERSPECTIVE_WARP_BILINEAR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PWB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwb assertion failed");
// next-cycle implication
`define PWB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwb assertion failed");
`else
`define PWB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PWB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/pwb_pkg.sv]
// ---------------------------------------------------------------------------
// pwb_pkg
// Shared types and constants of the perspective warp block.
// ---------------------------------------------------------------------------
package pwb_pkg;

  localparam int COEF_W    = 48;
  localparam int CRD_W     = 9;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;

  localparam int SRC_WIDTH_DEF  = 512;
  localparam int SRC_HEIGHT_DEF = 512;
  localparam int FRAC_BITS_DEF  = 8;

  // coefficient times zero-extended coordinate
  localparam int PROD_W = COEF_W + CRD_W + 1;
  // three-term sum plus room for negation
  localparam int NUM_W  = PROD_W + 3;
  localparam int MAG_W  = NUM_W - 1;

  localparam int FQ_DEPTH = 4;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << 32;
  localparam logic [NUM_W-1:0]  Q32_ONE  = NUM_W'(1) << 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_H_XX = 3'd0,
    REG_H_XY = 3'd1,
    REG_H_X0 = 3'd2,
    REG_H_YX = 3'd3,
    REG_H_YY = 3'd4,
    REG_H_Y0 = 3'd5,
    REG_H_WX = 3'd6,
    REG_H_WY = 3'd7
  } pwb_reg_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_WARP = 1'b1
  } pwb_op_t;

  typedef struct packed {
    logic             operation;
    logic [CRD_W-1:0] coord_x;
    logic [CRD_W-1:0] coord_y;
    logic [CH_W-1:0]  red_in;
    logic [CH_W-1:0]  green_in;
    logic [CH_W-1:0]  blue_in;
  } pwb_in_t;

  typedef struct packed {
    logic [CRD_W-1:0] out_x;
    logic [CRD_W-1:0] out_y;
    logic [CH_W-1:0]  red_out;
    logic [CH_W-1:0]  green_out;
    logic [CH_W-1:0]  blue_out;
    logic             zero_denominator;
  } pwb_out_t;

  // per-item sideband carried down the back pipeline
  typedef struct packed {
    logic             warp;
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [PIX_W-1:0] pix;
    logic             zero;
  } pwb_side_t;

endpackage

[src/pwb_front.sv]
// ---------------------------------------------------------------------------
// pwb_front
// Input side: takes beats, drops loads outside the image, queues the rest.
// ---------------------------------------------------------------------------
`include "perspective_warp_bilinear_assert.svh"

module pwb_front
  import pwb_pkg::*;
#(
  parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT = SRC_HEIGHT_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  output logic    full,
  input  pwb_in_t in_item,
  output logic    hd_valid,
  output pwb_in_t hd_item,
  input  logic    hd_pop
);

  localparam int PTR_W = $clog2(FQ_DEPTH);
  localparam int CNT_W = $clog2(FQ_DEPTH + 1);
  localparam int LIM_MAX = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
  localparam int CMP_W = $clog2(LIM_MAX + 1) + CRD_W;

  pwb_in_t          fq_r [FQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             keep;
  logic             do_push;
  logic             do_pop;

  // loads outside the store are accepted and dropped here
  assign keep = (in_item.operation == OP_WARP) ||
                ((CMP_W'(in_item.coord_x) < CMP_W'(SRC_WIDTH)) &&
                 (CMP_W'(in_item.coord_y) < CMP_W'(SRC_HEIGHT)));

  assign full     = (cnt_r == CNT_W'(FQ_DEPTH));
  assign hd_valid = (cnt_r != '0);
  assign hd_item  = fq_r[rd_ptr_r];
  assign do_push  = push && !full && keep;
  assign do_pop   = hd_pop && hd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      fq_r[wr_ptr_r] <= in_item;
    end
  end

  `PWB_ASSERT_IMP(a_fq_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(FQ_DEPTH))
  `PWB_ASSERT_NXT(a_fq_drop, clk, rst_n, push && !full && !keep && !hd_pop, cnt_r == $past(cnt_r))

endmodule

[src/pwb_div.sv]
// ---------------------------------------------------------------------------
// pwb_div
// Pipelined restoring divider for one axis, one quotient bit per stage,
// followed by the clamp to the image edge.
// ---------------------------------------------------------------------------
`include "perspective_warp_bilinear_assert.svh"

module pwb_div
  import pwb_pkg::*;
#(
  parameter int LIM       = SRC_WIDTH_DEF,
  parameter int KQ        = 9,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic [MAG_W-1:0]        den,
  output logic [$clog2(LIM)-1:0]  idx_o,
  output logic [FRAC_BITS:0]      frac_o
);

  localparam int IB = $clog2(LIM);
  localparam int QW = KQ + FRAC_BITS;
  localparam int RW = MAG_W + QW;
  localparam int FW = FRAC_BITS + 1;

  logic [RW-1:0]    r_r   [QW+1];
  logic [MAG_W-1:0] d_r   [QW+1];
  logic [QW-1:0]    q_r   [QW+1];
  logic             neg_r [QW+1];
  logic             ovf_r [QW+1];
  logic [IB-1:0]    idx_r;
  logic [FW-1:0]    frac_r;

  logic [MAG_W-1:0] mag;
  logic             neg_in;
  logic             ovf_in;
  logic [KQ-1:0]    q_int;

  assign neg_in = num[NUM_W-1];
  assign mag    = num[MAG_W-1:0];
  // quotient would not fit in KQ integer bits
  assign ovf_in = !neg_in && (RW'(mag) >= (RW'(den) << KQ));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r[0] <= 1'b0;
      ovf_r[0] <= 1'b0;
    end else if (en) begin
      neg_r[0] <= neg_in;
      ovf_r[0] <= ovf_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0] <= (neg_in || ovf_in) ? '0 : (RW'(mag) << FRAC_BITS);
      d_r[0] <= den;
      q_r[0] <= '0;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    logic [RW-1:0] cmp;
    logic          ge;
    assign cmp = RW'(d_r[s-1]) << (QW - s);
    assign ge  = (r_r[s-1] >= cmp);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        neg_r[s] <= 1'b0;
        ovf_r[s] <= 1'b0;
      end else if (en) begin
        neg_r[s] <= neg_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[s] <= ge ? (r_r[s-1] - cmp) : r_r[s-1];
        d_r[s] <= d_r[s-1];
        q_r[s] <= {q_r[s-1][QW-2:0], ge};
      end
    end
  end

  assign q_int = q_r[QW][QW-1:FRAC_BITS];

  // clamp: negative to the first column, past the edge to the last pair
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[QW]) begin
        idx_r  <= '0;
        frac_r <= '0;
      end else if (ovf_r[QW] || (q_int >= KQ'(LIM - 1))) begin
        idx_r  <= IB'(LIM - 2);
        frac_r <= FW'(1) << FRAC_BITS;
      end else begin
        idx_r  <= IB'(q_int);
        frac_r <= {1'b0, q_r[QW][FRAC_BITS-1:0]};
      end
    end
  end

  assign idx_o  = idx_r;
  assign frac_o = frac_r;

  `PWB_ASSERT_NXT(a_div_neg, clk, rst_n, en && neg_r[QW], idx_r == '0 && frac_r == '0)

endmodule

[src/pwb_store.sv]
// ---------------------------------------------------------------------------
// pwb_store
// Source image store in four banks split by row and column parity, so the
// 2x2 neighborhood comes out in one read.
// ---------------------------------------------------------------------------
module pwb_store
  import pwb_pkg::*;
#(
  parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT = SRC_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(SRC_WIDTH)-1:0]  rd_u,
  input  logic [$clog2(SRC_HEIGHT)-1:0] rd_v,
  input  logic                          wr_en,
  input  logic [CRD_W-1:0]              wr_x,
  input  logic [CRD_W-1:0]              wr_y,
  input  logic [PIX_W-1:0]              wr_data,
  output logic [PIX_W-1:0]              p00,
  output logic [PIX_W-1:0]              p01,
  output logic [PIX_W-1:0]              p10,
  output logic [PIX_W-1:0]              p11
);

  localparam int XB = $clog2(SRC_WIDTH);
  localparam int YB = $clog2(SRC_HEIGHT);
  localparam int CB = (XB > 1) ? XB - 1 : 1;
  localparam int RB = (YB > 1) ? YB - 1 : 1;
  localparam int AW = CB + RB;
  localparam int BANK_DEPTH = 1 << AW;

  logic [XB-1:0]    u1;
  logic [YB-1:0]    v1;
  logic [CB-1:0]    col_a [2];
  logic [RB-1:0]    row_a [2];
  logic [1:0]       wsel;
  logic [AW-1:0]    waddr;
  logic [PIX_W-1:0] rd_r [4];
  logic             upar_r;
  logic             vpar_r;

  // even bank holds the column at (u+1)>>1, odd bank at u>>1
  assign u1       = rd_u + XB'(1);
  assign v1       = rd_v + YB'(1);
  assign col_a[0] = CB'(u1 >> 1);
  assign col_a[1] = CB'(rd_u >> 1);
  assign row_a[0] = RB'(v1 >> 1);
  assign row_a[1] = RB'(rd_v >> 1);

  assign wsel  = {wr_y[0], wr_x[0]};
  assign waddr = {RB'(wr_y >> 1), CB'(wr_x >> 1)};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0] mem [BANK_DEPTH];
    logic [AW-1:0]    raddr;
    assign raddr = {row_a[b / 2], col_a[b % 2]};

    always_ff @(posedge clk) begin
      if (wr_en && (wsel == 2'(b))) begin
        mem[waddr] <= wr_data;
      end
      if (rd_en) begin
        rd_r[b] <= mem[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      upar_r <= rd_u[0];
      vpar_r <= rd_v[0];
    end
  end

  // bank index is {row parity, column parity}
  always_comb begin
    if (!vpar_r) begin
      p00 = upar_r ? rd_r[1] : rd_r[0];
      p10 = upar_r ? rd_r[0] : rd_r[1];
      p01 = upar_r ? rd_r[3] : rd_r[2];
      p11 = upar_r ? rd_r[2] : rd_r[3];
    end else begin
      p00 = upar_r ? rd_r[3] : rd_r[2];
      p10 = upar_r ? rd_r[2] : rd_r[3];
      p01 = upar_r ? rd_r[1] : rd_r[0];
      p11 = upar_r ? rd_r[0] : rd_r[1];
    end
  end

endmodule

[src/perspective_warp_bilinear.sv]
// ---------------------------------------------------------------------------
// perspective_warp_bilinear
// Homography warp of output pixels with bilinear sampling of a source image.
// ---------------------------------------------------------------------------
//  channel   ports                      beat
//  input     push / full / in_item      load pixel or warp request
//  result    empty / pop / out_item     one warped RGB pixel per warp
//  config    cfg_we / cfg_index / data  one 48-bit coefficient write
//
//  One beat per cycle sustained while results are popped. A warp passes
//  the queue, the product, sum and divisor stages, the bit-per-stage
//  divider and the blend stages; the divider is most of that path.
//  Synchronous active-low reset clears the queue, the pipeline valids and
//  the coefficients (identity). The image store is not cleared.
//  A result not popped stalls the back pipeline; the input queue keeps
//  taking beats until its four entries are used.
// ---------------------------------------------------------------------------
`include "perspective_warp_bilinear_assert.svh"

module perspective_warp_bilinear
  import pwb_pkg::*;
#(
  parameter int SRC_WIDTH  = SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT = SRC_HEIGHT_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  pwb_in_t              in_item,
  output logic                 empty,
  input  logic                 pop,
  output pwb_out_t             out_item,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  localparam int LIM_MAX = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
  localparam int KQ      = $clog2(LIM_MAX);
  localparam int XB      = $clog2(SRC_WIDTH);
  localparam int YB      = $clog2(SRC_HEIGHT);
  localparam int DIV_LAT = KQ + FRAC_BITS + 2;
  localparam int FW      = FRAC_BITS + 1;
  localparam int WW      = 2 * FRAC_BITS + 1;
  localparam int SW      = 2 * FRAC_BITS + 9;
  localparam logic [FW-1:0] F_ONE = FW'(1) << FRAC_BITS;
  localparam logic [SW-1:0] RND   = SW'(1) << (2 * FRAC_BITS - 1);

  // coefficients
  logic [COEF_W-1:0] h_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        h_r[i] <= (i == int'(REG_H_XX) || i == int'(REG_H_YY)) ? COEF_ONE : '0;
      end
    end else if (cfg_we) begin
      h_r[cfg_index] <= cfg_data;
    end
  end

  // front: queue of pending beats
  logic    fq_valid;
  pwb_in_t fq_item;
  logic    adv;

  pwb_front #(
    .SRC_WIDTH (SRC_WIDTH),
    .SRC_HEIGHT(SRC_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .hd_valid(fq_valid),
    .hd_item (fq_item),
    .hd_pop  (adv)
  );

  // the whole back pipeline moves together when the result slot frees up
  logic     out_vld_r;
  pwb_out_t out_r;
  assign adv = !out_vld_r || pop;

  // stage 1: products
  logic                     p1_vld_r;
  pwb_side_t                p1_side_r;
  logic signed [PROD_W-1:0] p1_ux_r, p1_uy_r, p1_vx_r, p1_vy_r, p1_wx_r, p1_wy_r;
  logic signed [CRD_W:0]    xs;
  logic signed [CRD_W:0]    ys;

  assign xs = {1'b0, fq_item.coord_x};
  assign ys = {1'b0, fq_item.coord_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (adv) begin
      p1_vld_r <= fq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_side_r.warp <= (fq_item.operation == OP_WARP);
      p1_side_r.x    <= fq_item.coord_x;
      p1_side_r.y    <= fq_item.coord_y;
      p1_side_r.pix  <= {fq_item.red_in, fq_item.green_in, fq_item.blue_in};
      p1_side_r.zero <= 1'b0;
      p1_ux_r <= $signed(h_r[REG_H_XX]) * xs;
      p1_uy_r <= $signed(h_r[REG_H_XY]) * ys;
      p1_vx_r <= $signed(h_r[REG_H_YX]) * xs;
      p1_vy_r <= $signed(h_r[REG_H_YY]) * ys;
      p1_wx_r <= $signed(h_r[REG_H_WX]) * xs;
      p1_wy_r <= $signed(h_r[REG_H_WY]) * ys;
    end
  end

  // stage 2: numerators and denominator, Q.32
  logic                    p2_vld_r;
  pwb_side_t               p2_side_r;
  logic signed [NUM_W-1:0] p2_nu_r, p2_nv_r, p2_w_r;

  function automatic logic signed [NUM_W-1:0] ext_p(logic signed [PROD_W-1:0] v);
    return {{(NUM_W - PROD_W){v[PROD_W-1]}}, v};
  endfunction

  function automatic logic signed [NUM_W-1:0] ext_c(logic [COEF_W-1:0] v);
    return {{(NUM_W - COEF_W){v[COEF_W-1]}}, v};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (adv) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_side_r <= p1_side_r;
      p2_nu_r   <= ext_p(p1_ux_r) + ext_p(p1_uy_r) + ext_c(h_r[REG_H_X0]);
      p2_nv_r   <= ext_p(p1_vx_r) + ext_p(p1_vy_r) + ext_c(h_r[REG_H_Y0]);
      p2_w_r    <= ext_p(p1_wx_r) + ext_p(p1_wy_r) + $signed(Q32_ONE);
    end
  end

  // stage 3: make the divisor positive; a zero divisor samples the origin
  logic                    p3_vld_r;
  pwb_side_t               p3_side_r;
  logic signed [NUM_W-1:0] p3_nu_r, p3_nv_r;
  logic [MAG_W-1:0]        p3_d_r;
  logic signed [NUM_W-1:0] w_neg;
  pwb_side_t               p2_side_z;

  assign w_neg = -p2_w_r;

  always_comb begin
    p2_side_z      = p2_side_r;
    p2_side_z.zero = (p2_w_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (adv) begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_side_r <= p2_side_z;
      if (p2_w_r == '0) begin
        p3_nu_r        <= '0;
        p3_nv_r        <= '0;
        p3_d_r         <= MAG_W'(1);
      end else if (p2_w_r[NUM_W-1]) begin
        p3_nu_r <= -p2_nu_r;
        p3_nv_r <= -p2_nv_r;
        p3_d_r  <= w_neg[MAG_W-1:0];
      end else begin
        p3_nu_r <= p2_nu_r;
        p3_nv_r <= p2_nv_r;
        p3_d_r  <= p2_w_r[MAG_W-1:0];
      end
    end
  end

  // dividers, one per axis, with a matching sideband line
  logic [XB-1:0]    u_idx;
  logic [YB-1:0]    v_idx;
  logic [FW-1:0]    t_frac;
  logic [FW-1:0]    s_frac;

  pwb_div #(
    .LIM      (SRC_WIDTH),
    .KQ       (KQ),
    .FRAC_BITS(FRAC_BITS)
  ) u_div_u (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .num   (p3_nu_r),
    .den   (p3_d_r),
    .idx_o (u_idx),
    .frac_o(t_frac)
  );

  pwb_div #(
    .LIM      (SRC_HEIGHT),
    .KQ       (KQ),
    .FRAC_BITS(FRAC_BITS)
  ) u_div_v (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .num   (p3_nv_r),
    .den   (p3_d_r),
    .idx_o (v_idx),
    .frac_o(s_frac)
  );

  logic [DIV_LAT-1:0] sb_vld_r;
  pwb_side_t          sb_side_r [DIV_LAT];
  logic               p4_vld;
  pwb_side_t          p4_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_vld_r <= '0;
    end else if (adv) begin
      sb_vld_r <= {sb_vld_r[DIV_LAT-2:0], p3_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_side_r[0] <= p3_side_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        sb_side_r[i] <= sb_side_r[i-1];
      end
    end
  end

  assign p4_vld  = sb_vld_r[DIV_LAT-1];
  assign p4_side = sb_side_r[DIV_LAT-1];

  // stage 5: store read (warps) or write (loads), corner weights
  logic [PIX_W-1:0] px00, px01, px10, px11;
  logic             p5_vld_r;
  pwb_side_t        p5_side_r;
  logic [WW-1:0]    p5_w00_r, p5_w01_r, p5_w10_r, p5_w11_r;
  logic [FW-1:0]    nt;
  logic [FW-1:0]    ns;

  // loads write at the same stage warps read, so store order is beat order
  pwb_store #(
    .SRC_WIDTH (SRC_WIDTH),
    .SRC_HEIGHT(SRC_HEIGHT)
  ) u_store (
    .clk    (clk),
    .rd_en  (adv),
    .rd_u   (u_idx),
    .rd_v   (v_idx),
    .wr_en  (adv && p4_vld && !p4_side.warp),
    .wr_x   (p4_side.x),
    .wr_y   (p4_side.y),
    .wr_data(p4_side.pix),
    .p00    (px00),
    .p01    (px01),
    .p10    (px10),
    .p11    (px11)
  );

  assign nt = F_ONE - t_frac;
  assign ns = F_ONE - s_frac;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_vld_r <= 1'b0;
    end else if (adv) begin
      p5_vld_r <= p4_vld && p4_side.warp;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p5_side_r <= p4_side;
      p5_w00_r  <= WW'(nt) * WW'(ns);
      p5_w01_r  <= WW'(nt) * WW'(s_frac);
      p5_w10_r  <= WW'(t_frac) * WW'(ns);
      p5_w11_r  <= WW'(t_frac) * WW'(s_frac);
    end
  end

  // stage 6: weighted channel terms, channel 0 = red
  logic          p6_vld_r;
  pwb_side_t     p6_side_r;
  logic [SW-1:0] p6_prod_r [3][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_vld_r <= 1'b0;
    end else if (adv) begin
      p6_vld_r <= p5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p6_side_r <= p5_side_r;
      for (int c = 0; c < 3; c++) begin
        p6_prod_r[c][0] <= SW'(p5_w00_r) * SW'(px00[PIX_W-1-CH_W*c -: CH_W]);
        p6_prod_r[c][1] <= SW'(p5_w01_r) * SW'(px01[PIX_W-1-CH_W*c -: CH_W]);
        p6_prod_r[c][2] <= SW'(p5_w10_r) * SW'(px10[PIX_W-1-CH_W*c -: CH_W]);
        p6_prod_r[c][3] <= SW'(p5_w11_r) * SW'(px11[PIX_W-1-CH_W*c -: CH_W]);
      end
    end
  end

  // stage 7: sum, round to nearest, result register
  logic [SW-1:0] ch_sum [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ch_sum[c] = p6_prod_r[c][0] + p6_prod_r[c][1] + p6_prod_r[c][2] +
                  p6_prod_r[c][3] + RND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= p6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.out_x            <= p6_side_r.x;
      out_r.out_y            <= p6_side_r.y;
      out_r.red_out          <= ch_sum[0][2*FRAC_BITS +: CH_W];
      out_r.green_out        <= ch_sum[1][2*FRAC_BITS +: CH_W];
      out_r.blue_out         <= ch_sum[2][2*FRAC_BITS +: CH_W];
      out_r.zero_denominator <= p6_side_r.zero;
    end
  end

  assign empty    = !out_vld_r;
  assign out_item = out_r;

  `PWB_ASSERT_NXT(a_stall_hold, clk, rst_n, !adv, $stable(sb_vld_r))

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: perspective warp with bilinear sampling
// Directed table, then random load and warp beats across several coefficient
// sets; every warp result is checked against its typed table pixel or an
// in-bench fixed-point predictor of the homography, clamp and blend.
// ---------------------------------------------------------------------------
module tb;
  import pwb_pkg::*;

  localparam int IMG_W      = SRC_WIDTH_DEF;
  localparam int IMG_H      = SRC_HEIGHT_DEF;
  localparam int FRAC       = FRAC_BITS_DEF;
  localparam int ONE_W      = 1 << FRAC;
  localparam int DRAIN_CYC  = 40;    // pipeline depth is about 25
  localparam int HOLD_CYC   = 300;   // long receiver hold-off
  localparam int WDOG_LIMIT = 4000;
  localparam int ITEM_GOAL  = 1900;

  // directed row kinds
  typedef enum logic [1:0] {ROW_LOAD, ROW_WARP, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    int          x;
    int          y;
    logic [23:0] rgb;        // load pixel, or typed expected pixel
    pwb_reg_t    idx;
    logic [47:0] data;
    bit          typed;      // warp row carries its own expected result
    bit          zero;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  pwb_in_t     in_item;
  logic        empty;
  logic        pop;
  pwb_out_t    out_item;
  logic        cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  perspective_warp_bilinear dut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state: coefficient copy and the written part of the image
  logic signed [47:0] coef [NUM_REGS];
  logic [23:0]        image_px [int];
  pwb_out_t           pending_px [$];

  int  n_bad;
  int  n_items;
  int  n_warps;
  int  n_zero;
  int  n_results;
  int  idle_pct;
  int  stall_pct;
  int  hold_left;
  bit  hold_req;
  int  quiet_cyc;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // -------------------------------------------------------------------------
  // predictor
  // -------------------------------------------------------------------------

  // floor(num/den) split into clamped index and FRAC-bit fraction
  function automatic void axis_map(input longint num, input longint den, input int lim,
                                   output int idx, output int frac);
    longint q, r;
    longint unsigned ur, ud;
    int f;
    f = 0;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    q = num / den;
    r = num % den;
    if (r < 0) begin
      q = q - 1;
      r = r + den;
    end
    if (q < 0) begin
      idx = 0;
      frac = 0;
    end else if (q >= lim - 1) begin
      idx = lim - 2;
      frac = ONE_W;
    end else begin
      ur = r;
      ud = den;
      for (int i = 0; i < FRAC; i++) begin
        ur = ur << 1;
        f = f << 1;
        if (ur >= ud) begin
          ur = ur - ud;
          f = f | 1;
        end
      end
      idx = int'(q);
      frac = f;
    end
  endfunction

  // source index and weights of one output pixel
  function automatic void homography_map(input int x, input int y,
                                         output int ix, output int iy,
                                         output int t, output int s, output bit zero);
    longint nu, nv, w;
    nu = longint'(coef[REG_H_XX]) * x + longint'(coef[REG_H_XY]) * y + longint'(coef[REG_H_X0]);
    nv = longint'(coef[REG_H_YX]) * x + longint'(coef[REG_H_YY]) * y + longint'(coef[REG_H_Y0]);
    w  = longint'(coef[REG_H_WX]) * x + longint'(coef[REG_H_WY]) * y + (longint'(1) << 32);
    ix = 0; iy = 0; t = 0; s = 0;
    zero = (w == 0);
    if (!zero) begin
      axis_map(nu, w, IMG_W, ix, t);
      axis_map(nv, w, IMG_H, iy, s);
    end
  endfunction

  function automatic logic [7:0] bilerp(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c, input logic [7:0] d,
                                        input int t, input int s);
    longint unsigned nt, ns, sum;
    nt = ONE_W - t;
    ns = ONE_W - s;
    sum = nt * ns * a + nt * s * b + t * ns * c + longint'(t) * s * d;
    sum = sum + (longint'(1) << (2 * FRAC - 1));
    return 8'(sum >> (2 * FRAC));
  endfunction

  function automatic pwb_out_t warp_pixel(input int x, input int y);
    int ix, iy, t, s, base;
    bit zero;
    logic [23:0] p00, p01, p10, p11;
    pwb_out_t o;
    homography_map(x, y, ix, iy, t, s, zero);
    base = iy * IMG_W + ix;
    p00 = image_px[base];
    p10 = image_px[base + 1];
    p01 = image_px[base + IMG_W];
    p11 = image_px[base + IMG_W + 1];
    o.out_x = CRD_W'(x);
    o.out_y = CRD_W'(y);
    o.red_out   = bilerp(p00[23:16], p01[23:16], p10[23:16], p11[23:16], t, s);
    o.green_out = bilerp(p00[15:8],  p01[15:8],  p10[15:8],  p11[15:8],  t, s);
    o.blue_out  = bilerp(p00[7:0],   p01[7:0],   p10[7:0],   p11[7:0],   t, s);
    o.zero_denominator = zero;
    return o;
  endfunction

  // -------------------------------------------------------------------------
  // input side
  // -------------------------------------------------------------------------

  // offer one beat with random idling; returns once it is taken
  task automatic push_beat(input pwb_in_t it, input bit typed, input pwb_out_t typed_px);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    n_items++;
    if (it.operation == OP_LOAD) begin
      image_px[int'(it.coord_y) * IMG_W + int'(it.coord_x)] =
        {it.red_in, it.green_in, it.blue_in};
    end else begin
      n_warps++;
      if (typed) pending_px = {pending_px, typed_px};
      else pending_px = {pending_px, warp_pixel(int'(it.coord_x), int'(it.coord_y))};
    end
  endtask

  task automatic load_px(input int x, input int y, input logic [23:0] rgb);
    pwb_in_t it;
    pwb_out_t none;
    none = '0;
    it.operation = OP_LOAD;
    it.coord_x = CRD_W'(x);
    it.coord_y = CRD_W'(y);
    {it.red_in, it.green_in, it.blue_in} = rgb;
    push_beat(it, 1'b0, none);
  endtask

  // warp beat; first loads any neighbor that was never written
  task automatic warp_px(input int x, input int y, input bit typed, input pwb_out_t typed_px);
    int ix, iy, t, s;
    bit zero;
    pwb_in_t it;
    homography_map(x, y, ix, iy, t, s, zero);
    for (int dy = 0; dy < 2; dy++)
      for (int dx = 0; dx < 2; dx++)
        if (!image_px.exists((iy + dy) * IMG_W + ix + dx))
          load_px(ix + dx, iy + dy, 24'($urandom));
    it = '0;
    it.operation = OP_WARP;
    it.coord_x = CRD_W'(x);
    it.coord_y = CRD_W'(y);
    {it.red_in, it.green_in, it.blue_in} = 24'($urandom);
    push_beat(it, typed, typed_px);
  endtask

  // drain the block completely, then write one coefficient
  task automatic write_coef(input pwb_reg_t idx, input logic [47:0] data);
    push <= 1'b0;
    wait (pending_px.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    coef[idx] = data;
  endtask

  // -------------------------------------------------------------------------
  // result side: random pop, long hold-off on request, checking
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_results++;
        if (pending_px.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result beat: %p", out_item);
        end else begin
          pwb_out_t e;
          e = pending_px.pop_front();
          if (e.zero_denominator) n_zero++;
          if (out_item.out_x !== e.out_x || out_item.out_y !== e.out_y ||
              out_item.red_out !== e.red_out || out_item.green_out !== e.green_out ||
              out_item.blue_out !== e.blue_out ||
              out_item.zero_denominator !== e.zero_denominator) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch at (%0d,%0d): exp rgb %h%h%h z%0d, got (%0d,%0d) %h%h%h z%0d",
                       e.out_x, e.out_y, e.red_out, e.green_out, e.blue_out,
                       e.zero_denominator, out_item.out_x, out_item.out_y,
                       out_item.red_out, out_item.green_out, out_item.blue_out,
                       out_item.zero_denominator);
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYC;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog: cycles in which no beat moves on any port
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || cfg_we) begin
      quiet_cyc <= 0;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
      if (quiet_cyc >= WDOG_LIMIT) begin
        $display("watchdog expired, %0d results still expected", pending_px.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic longint rnd_coef(input int bits);
    return $signed({$urandom, $urandom}) >>> (64 - bits);
  endfunction

  function automatic void set_mode(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 72; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 72; end
      default: begin idle_pct = 9; stall_pct = 9; end
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // directed table
  // -------------------------------------------------------------------------
  localparam logic [47:0] Q_ONE  = 48'h0001_0000_0000;
  localparam logic [47:0] Q_HALF = 48'h0000_8000_0000;
  localparam logic [47:0] Q_MAX  = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] Q_MIN  = 48'h8000_0000_0000;
  localparam logic [47:0] Q_NEG1 = 48'hFFFF_0000_0000;

  row_t plan [] = '{
    '{ROW_LOAD, 0,   0,   24'hFF00FF, REG_H_XX, '0, 0, 0},
    '{ROW_LOAD, 1,   0,   24'h00FF00, REG_H_XX, '0, 0, 0},
    '{ROW_LOAD, 0,   1,   24'h123456, REG_H_XX, '0, 0, 0},
    '{ROW_LOAD, 1,   1,   24'hFFFFFF, REG_H_XX, '0, 0, 0},
    '{ROW_LOAD, 510, 510, 24'h000000, REG_H_XX, '0, 0, 0},
    '{ROW_LOAD, 511, 510, 24'hA5A5A5, REG_H_XX, '0, 0, 0},
    '{ROW_LOAD, 510, 511, 24'h5A5A5A, REG_H_XX, '0, 0, 0},
    '{ROW_LOAD, 511, 511, 24'hC3017E, REG_H_XX, '0, 0, 0},
    // identity after reset: origin, and far corner clamped to full weight
    '{ROW_WARP, 0,   0,   24'hFF00FF, REG_H_XX, '0, 1, 0},
    '{ROW_WARP, 511, 511, 24'hC3017E, REG_H_XX, '0, 1, 0},
    '{ROW_WARP, 1,   0,   '0,         REG_H_XX, '0, 0, 0},
    // half scale: four-way blend of the origin block, then a warp at x = 511
    '{ROW_CFG,  0,   0,   '0,         REG_H_XX, Q_HALF, 0, 0},
    '{ROW_CFG,  0,   0,   '0,         REG_H_YY, Q_HALF, 0, 0},
    '{ROW_WARP, 1,   1,   '0,         REG_H_XX, '0, 0, 0},
    '{ROW_WARP, 511, 0,   '0,         REG_H_XX, '0, 0, 0},
    // w = 1 - x: zero denominator at x = 1 samples the origin
    '{ROW_CFG,  0,   0,   '0,         REG_H_WX, Q_NEG1, 0, 0},
    '{ROW_WARP, 1,   0,   24'hFF00FF, REG_H_XX, '0, 1, 1},
    '{ROW_WARP, 0,   7,   '0,         REG_H_XX, '0, 0, 0},
    '{ROW_WARP, 2,   5,   '0,         REG_H_XX, '0, 0, 0},
    '{ROW_CFG,  0,   0,   '0,         REG_H_WX, '0, 0, 0},
    // most negative coefficient: index 0; most positive: the last pair
    '{ROW_CFG,  0,   0,   '0,         REG_H_XX, Q_MIN, 0, 0},
    '{ROW_WARP, 5,   0,   24'hFF00FF, REG_H_XX, '0, 1, 0},
    '{ROW_CFG,  0,   0,   '0,         REG_H_XX, Q_MAX, 0, 0},
    '{ROW_WARP, 3,   2,   '0,         REG_H_XX, '0, 0, 0}
  };

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    pwb_out_t px;
    logic [47:0] set [NUM_REGS];
    int goal;
    bit held;
    bit paused;
    rst_n <= 1'b0;
    push <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    n_bad = 0; n_items = 0; n_warps = 0; n_zero = 0; n_results = 0;
    hold_left = 0; hold_req = 1'b0;
    held = 1'b0; paused = 1'b0;
    for (int i = 0; i < NUM_REGS; i++) coef[i] = '0;
    coef[REG_H_XX] = Q_ONE;
    coef[REG_H_YY] = Q_ONE;
    set_mode(0);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_LOAD: load_px(plan[i].x, plan[i].y, plan[i].rgb);
        ROW_CFG:  write_coef(plan[i].idx, plan[i].data);
        default: begin
          px.out_x = CRD_W'(plan[i].x);
          px.out_y = CRD_W'(plan[i].y);
          {px.red_out, px.green_out, px.blue_out} = plan[i].rgb;
          px.zero_denominator = plan[i].zero;
          warp_px(plan[i].x, plan[i].y, plan[i].typed, px);
        end
      endcase
    end

    // random phases, one coefficient set each
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < NUM_REGS; i++) set[i] = '0;
      set[REG_H_XX] = Q_ONE;
      set[REG_H_YY] = Q_ONE;
      case (ph) inside
        1, 2: begin
          // near-affine, with mild perspective in the second one
          set[REG_H_XX] = 48'(Q_ONE + rnd_coef(33));
          set[REG_H_XY] = 48'(rnd_coef(31));
          set[REG_H_X0] = 48'(rnd_coef(40));
          set[REG_H_YX] = 48'(rnd_coef(31));
          set[REG_H_YY] = 48'(Q_ONE + rnd_coef(33));
          set[REG_H_Y0] = 48'(rnd_coef(40));
          if (ph == 2) begin
            set[REG_H_WX] = 48'(rnd_coef(23));
            set[REG_H_WY] = 48'(rnd_coef(23));
          end
        end
        3: for (int i = 0; i < NUM_REGS; i++) set[i] = 48'(rnd_coef(48));
        4: begin
          // w vanishes on the line x/8 + y/16 = 1
          set[REG_H_WX] = 48'hFFFF_E000_0000;
          set[REG_H_WY] = 48'hFFFF_F000_0000;
        end
        5: begin
          set[REG_H_XX] = Q_MAX; set[REG_H_XY] = Q_MIN; set[REG_H_X0] = Q_MAX;
          set[REG_H_YX] = Q_MIN; set[REG_H_YY] = Q_MAX; set[REG_H_Y0] = Q_MIN;
          set[REG_H_WX] = Q_MAX; set[REG_H_WY] = Q_MIN;
        end
        default: ;
      endcase
      for (int i = 0; i < NUM_REGS; i++) write_coef(pwb_reg_t'(i), set[i]);
      set_mode(ph % 4);
      goal = n_items + ITEM_GOAL / 6;
      while (n_items < goal) begin
        if (ph == 1 && !held && n_items >= goal - 200) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        if (ph == 2 && !paused && n_items >= goal - 150) begin
          // sender pause until the block has drained
          paused = 1'b1;
          push <= 1'b0;
          wait (pending_px.size() == 0);
          @(posedge clk);
        end
        if ($urandom_range(3) == 0) begin
          load_px($urandom_range(IMG_W - 1), $urandom_range(IMG_H - 1), 24'($urandom));
        end else if (ph == 4 && $urandom_range(1) == 0) begin
          warp_px($urandom_range(8), $urandom_range(16), 1'b0, px);
        end else begin
          warp_px($urandom_range(IMG_W - 1), $urandom_range(IMG_H - 1), 1'b0, px);
        end
      end
    end

    push <= 1'b0;
    wait (pending_px.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    $display("%0d beats in, %0d warps, %0d results checked, %0d with zero w",
             n_items, n_warps, n_results, n_zero);
    $display("six coefficient sets from identity to full-scale extremes, four idle modes");
    if (n_bad == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching beats", n_bad);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/pwb_pkg.sv
src/pwb_front.sv
src/pwb_div.sv
src/pwb_store.sv
src/perspective_warp_bilinear.sv
dv/tb.sv
